[sv/two_class_busy_interval_union_core_defines.svh]
// ----------------------------------------------------------------------------
// Two-class busy interval union core: assertion macros
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_BUSY_INTERVAL_UNION_CORE_DEFINES_SVH
`define TWO_CLASS_BUSY_INTERVAL_UNION_CORE_DEFINES_SVH

// same-cycle implication
`define TCBIU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCBIU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/tcbiu_pkg.sv]
// ----------------------------------------------------------------------------
// tcbiu_pkg
// Types and constants of the two-class busy interval union core.
// ----------------------------------------------------------------------------
package tcbiu_pkg;

  localparam int unsigned TS_W             = 64;
  localparam int unsigned ACT_W            = 8;
  localparam int unsigned ACT_LIMIT        = (1 << ACT_W) - 1;
  localparam int unsigned DEF_MAX_INFLIGHT = 255;

  localparam logic MODE_ENTER = 1'b0;
  localparam logic MODE_EXIT  = 1'b1;

  typedef enum logic [1:0] {
    ERR_OK         = 2'd0,
    ERR_EMPTY_EXIT = 2'd1,
    ERR_SATURATED  = 2'd2
  } evt_err_t;

  typedef struct packed {
    logic            mode;
    logic            class_a;
    logic [TS_W-1:0] timestamp_ns;
  } evt_item_t;

  typedef struct packed {
    logic [TS_W-1:0]  a_busy_ns;
    logic [TS_W-1:0]  b_busy_ns;
    logic [TS_W-1:0]  overlap_ns;
    logic [TS_W-1:0]  a_ops;
    logic [TS_W-1:0]  b_ops;
    logic [ACT_W-1:0] a_peak;
    logic [ACT_W-1:0] b_peak;
    logic [ACT_W-1:0] a_inflight;
    logic [ACT_W-1:0] b_inflight;
    logic [1:0]       event_error;
  } rpt_item_t;

endpackage

[sv/tcbiu_stream_if.sv]
// ----------------------------------------------------------------------------
// tcbiu_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface tcbiu_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/two_class_busy_interval_union_core.sv]
// ----------------------------------------------------------------------------
// two_class_busy_interval_union_core
// Busy-time monitor for two overlapping operation classes: union busy time
// per class, overlap time, enter counts, in-flight and peak depth.
//
//   channel  dir  payload      per transfer
//   evt      in   evt_item_t   one enter/exit event
//   rpt      out  rpt_item_t   counters after that event
//
// One event per cycle sustained while rpt is not stalled; each event passes
// the input register, then the state update and result register.
// The state update is a single pass: a 64-bit subtract and add per accumulator.
// rst (synchronous) clears all counters and start stamps.
// A stalled rpt holds its result; evt stays open while the input register
// can move on.
// ----------------------------------------------------------------------------
`include "two_class_busy_interval_union_core_defines.svh"

module two_class_busy_interval_union_core
  import tcbiu_pkg::*;
#(
  parameter int unsigned MAX_INFLIGHT = DEF_MAX_INFLIGHT
) (
  input  logic          clk,
  input  logic          rst,
  tcbiu_stream_if.sink   evt,
  tcbiu_stream_if.source rpt
);

  localparam logic [ACT_W-1:0] CAP =
    ACT_W'((MAX_INFLIGHT > ACT_LIMIT) ? ACT_LIMIT : MAX_INFLIGHT);
  localparam logic [ACT_W-1:0] ACT_ONE = ACT_W'(1);
  localparam logic [TS_W-1:0]  CNT_ONE = TS_W'(1);

  logic      item_v;
  evt_item_t item;
  logic      rpt_v;
  rpt_item_t rpt_q;
  logic      adv;

  logic [ACT_W-1:0] a_active, b_active, a_max, b_max;
  logic [TS_W-1:0]  a_start, b_start, ovl_start;
  logic [TS_W-1:0]  a_total, b_total, both_total, a_count, b_count;

  logic [ACT_W-1:0] a_active_next, b_active_next, a_max_next, b_max_next;
  logic [TS_W-1:0]  a_start_next, b_start_next, ovl_start_next;
  logic [TS_W-1:0]  a_total_next, b_total_next, both_total_next;
  logic [TS_W-1:0]  a_count_next, b_count_next;

  logic [ACT_W-1:0] sel_act, sel_act_upd, sel_peak;
  logic [TS_W-1:0]  sel_start, sel_total, sel_total_upd, ts;
  logic             is_enter, act_inc, act_dec, pre_both, now_both;
  evt_err_t         err;

  assign adv       = item_v && (!rpt_v || rpt.ready);
  assign evt.ready = !item_v || adv;
  assign rpt.valid = rpt_v;
  assign rpt.data  = rpt_q;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_v <= 1'b0;
    end else if (evt.ready) begin
      item_v <= evt.valid;
    end
    if (evt.valid && evt.ready) begin
      item <= evt.data;
    end
  end

  // event update
  always_comb begin
    ts        = item.timestamp_ns;
    is_enter  = (item.mode == MODE_ENTER);
    sel_act   = item.class_a ? a_active : b_active;
    sel_peak  = item.class_a ? a_max : b_max;
    sel_start = item.class_a ? a_start : b_start;
    sel_total = item.class_a ? a_total : b_total;

    act_inc = is_enter && (sel_act < CAP);
    act_dec = !is_enter && (sel_act != '0);

    if (act_inc) begin
      sel_act_upd = sel_act + ACT_ONE;
    end else if (act_dec) begin
      sel_act_upd = sel_act - ACT_ONE;
    end else begin
      sel_act_upd = sel_act;
    end

    sel_total_upd = sel_total + (ts - sel_start);

    a_active_next = item.class_a ? sel_act_upd : a_active;
    b_active_next = item.class_a ? b_active : sel_act_upd;
    pre_both      = (a_active != '0) && (b_active != '0);
    now_both      = (a_active_next != '0) && (b_active_next != '0);

    a_max_next      = a_max;
    b_max_next      = b_max;
    a_start_next    = a_start;
    b_start_next    = b_start;
    a_total_next    = a_total;
    b_total_next    = b_total;
    a_count_next    = a_count;
    b_count_next    = b_count;
    ovl_start_next  = ovl_start;
    both_total_next = both_total;

    if (is_enter) begin
      if (item.class_a) begin
        a_count_next = a_count + CNT_ONE;
      end else begin
        b_count_next = b_count + CNT_ONE;
      end
    end

    if (act_inc && sel_act_upd > sel_peak) begin
      if (item.class_a) begin
        a_max_next = sel_act_upd;
      end else begin
        b_max_next = sel_act_upd;
      end
    end

    if (act_inc && sel_act == '0) begin
      if (item.class_a) begin
        a_start_next = ts;
      end else begin
        b_start_next = ts;
      end
    end

    if (act_dec && sel_act_upd == '0 && sel_start != '0) begin
      if (item.class_a) begin
        a_total_next = sel_total_upd;
      end else begin
        b_total_next = sel_total_upd;
      end
    end

    if (is_enter && !pre_both && now_both) begin
      ovl_start_next = ts;
    end
    if (act_dec && pre_both && !now_both && ovl_start != '0) begin
      both_total_next = both_total + (ts - ovl_start);
    end

    if (is_enter && !act_inc) begin
      err = ERR_SATURATED;
    end else if (!is_enter && !act_dec) begin
      err = ERR_EMPTY_EXIT;
    end else begin
      err = ERR_OK;
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_active   <= '0;
      b_active   <= '0;
      a_start    <= '0;
      b_start    <= '0;
      ovl_start  <= '0;
      a_total    <= '0;
      b_total    <= '0;
      both_total <= '0;
      a_count    <= '0;
      b_count    <= '0;
      a_max      <= '0;
      b_max      <= '0;
      rpt_v      <= 1'b0;
    end else begin
      if (adv) begin
        a_active   <= a_active_next;
        b_active   <= b_active_next;
        a_start    <= a_start_next;
        b_start    <= b_start_next;
        ovl_start  <= ovl_start_next;
        a_total    <= a_total_next;
        b_total    <= b_total_next;
        both_total <= both_total_next;
        a_count    <= a_count_next;
        b_count    <= b_count_next;
        a_max      <= a_max_next;
        b_max      <= b_max_next;
        rpt_v      <= 1'b1;
      end else if (rpt.ready) begin
        rpt_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rpt_q.a_busy_ns   <= a_total_next;
      rpt_q.b_busy_ns   <= b_total_next;
      rpt_q.overlap_ns  <= both_total_next;
      rpt_q.a_ops       <= a_count_next;
      rpt_q.b_ops       <= b_count_next;
      rpt_q.a_peak      <= a_max_next;
      rpt_q.b_peak      <= b_max_next;
      rpt_q.a_inflight  <= a_active_next;
      rpt_q.b_inflight  <= b_active_next;
      rpt_q.event_error <= err;
    end
  end

  `TCBIU_ASSERT_IMP(a_cap_chk, 1'b1, (a_active <= CAP) && (b_active <= CAP), "above cap")
  `TCBIU_ASSERT_IMP(peak_chk, 1'b1, (a_max >= a_active) && (b_max >= b_active), "peak low")
  `TCBIU_ASSERT_NXT(adv_chk, adv, rpt.valid, "advanced event produced no result")
  `TCBIU_ASSERT_NXT(sat_chk, adv && err == ERR_SATURATED, $stable({a_active, b_active}), "moved")

endmodule

[tb/tb_two_class_busy_interval_union_core.sv]
// ----------------------------------------------------------------------------
// tb_two_class_busy_interval_union_core
// Self-checking bench for the two-class busy interval union core. Enter and
// exit events go in on the evt channel. Each accepted event is run through a
// behavioral copy of the counters, and every rpt transfer is compared field
// by field with the oldest pending report. Directed corner events come
// first, then both classes are driven to in-flight saturation, then a long
// random walk runs with bursty stalls on both channels.
// ----------------------------------------------------------------------------
module tb_two_class_busy_interval_union_core;
  timeunit 1ns;
  timeprecision 1ps;

  import tcbiu_pkg::*;

  localparam logic CLASS_A    = 1'b1;
  localparam logic CLASS_B    = 1'b0;
  localparam int   RAND_ITEMS = 850;
  localparam int   SAT_ENTERS = 258;

  class busy_union_scoreboard;
    localparam int unsigned CAP =
      (DEF_MAX_INFLIGHT > ACT_LIMIT) ? ACT_LIMIT : DEF_MAX_INFLIGHT;

    logic [ACT_W-1:0] a_act, b_act, a_pk, b_pk;
    logic [TS_W-1:0]  a_start, b_start, ovl_start;
    logic [TS_W-1:0]  a_busy, b_busy, overlap, a_enters, b_enters;
    rpt_item_t        expected_reports[$];
    int errors, n_events, n_enters, n_empty_exits, n_saturated, n_checked;

    function new();
      a_act = '0; b_act = '0; a_pk = '0; b_pk = '0;
      a_start = '0; b_start = '0; ovl_start = '0;
      a_busy = '0; b_busy = '0; overlap = '0; a_enters = '0; b_enters = '0;
      errors = 0; n_events = 0; n_enters = 0;
      n_empty_exits = 0; n_saturated = 0; n_checked = 0;
    endfunction

    function int outstanding();
      return expected_reports.size();
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    // advance the counters by one event and queue the resulting report
    function void note_event(evt_item_t ev);
      rpt_item_t        r;
      logic [TS_W-1:0]  t;
      logic [ACT_W-1:0] depth;
      bit               is_a, pre_both, now_both;
      evt_err_t         err;
      t        = ev.timestamp_ns;
      is_a     = (ev.class_a == CLASS_A);
      depth    = is_a ? a_act : b_act;
      pre_both = (a_act != 0) && (b_act != 0);
      err      = ERR_OK;
      n_events++;
      if (ev.mode == MODE_ENTER) begin
        n_enters++;
        if (is_a) a_enters++;
        else b_enters++;
        if (depth >= CAP) begin
          err = ERR_SATURATED;
          n_saturated++;
        end else if (is_a) begin
          if (a_act == 0) a_start = t;
          a_act++;
          if (a_act > a_pk) a_pk = a_act;
        end else begin
          if (b_act == 0) b_start = t;
          b_act++;
          if (b_act > b_pk) b_pk = b_act;
        end
        now_both = (a_act != 0) && (b_act != 0);
        if (!pre_both && now_both) ovl_start = t;
      end else if (depth == 0) begin
        err = ERR_EMPTY_EXIT;
        n_empty_exits++;
      end else begin
        if (is_a) begin
          a_act--;
          if (a_act == 0 && a_start != 0) a_busy += t - a_start;
        end else begin
          b_act--;
          if (b_act == 0 && b_start != 0) b_busy += t - b_start;
        end
        now_both = (a_act != 0) && (b_act != 0);
        if (pre_both && !now_both && ovl_start != 0) overlap += t - ovl_start;
      end
      r.a_busy_ns   = a_busy;
      r.b_busy_ns   = b_busy;
      r.overlap_ns  = overlap;
      r.a_ops       = a_enters;
      r.b_ops       = b_enters;
      r.a_peak      = a_pk;
      r.b_peak      = b_pk;
      r.a_inflight  = a_act;
      r.b_inflight  = b_act;
      r.event_error = err;
      expected_reports.push_back(r);
    endfunction

    task cmp_field(string fld, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report($sformatf("report %0d %s got 0x%0h exp 0x%0h", n_checked, fld, got, want));
    endtask

    task check_report(rpt_item_t got);
      rpt_item_t want;
      if (expected_reports.size() == 0) begin
        report("report transfer with no event pending");
        return;
      end
      want = expected_reports.pop_front();
      cmp_field("a_busy_ns", got.a_busy_ns, want.a_busy_ns);
      cmp_field("b_busy_ns", got.b_busy_ns, want.b_busy_ns);
      cmp_field("overlap_ns", got.overlap_ns, want.overlap_ns);
      cmp_field("a_ops", got.a_ops, want.a_ops);
      cmp_field("b_ops", got.b_ops, want.b_ops);
      cmp_field("a_peak", 64'(got.a_peak), 64'(want.a_peak));
      cmp_field("b_peak", 64'(got.b_peak), 64'(want.b_peak));
      cmp_field("a_inflight", 64'(got.a_inflight), 64'(want.a_inflight));
      cmp_field("b_inflight", 64'(got.b_inflight), 64'(want.b_inflight));
      cmp_field("event_error", 64'(got.event_error), 64'(want.event_error));
      n_checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  tcbiu_stream_if #(.payload_t(evt_item_t)) evt_if ();
  tcbiu_stream_if #(.payload_t(rpt_item_t)) rpt_if ();

  two_class_busy_interval_union_core #(
    .MAX_INFLIGHT(DEF_MAX_INFLIGHT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .evt(evt_if),
    .rpt(rpt_if)
  );

  busy_union_scoreboard sb = new();

  bit              send_idle = 1'b1;
  bit              recv_idle = 1'b1;
  bit              hold_req  = 1'b0;
  int              hold_cycles;
  int              drv_depth[2];
  logic [TS_W-1:0] t_now;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (evt_if.valid && evt_if.ready) sb.note_event(evt_if.data);
      if (rpt_if.valid && rpt_if.ready) sb.check_report(rpt_if.data);
    end
  end

  // report side: random stall bursts, plus one long hold on request
  initial begin
    rpt_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        rpt_if.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
      end else if (recv_idle && $urandom_range(0, 5) == 0) begin
        rpt_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        rpt_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic push_event(logic mode, logic cls, logic [TS_W-1:0] ts);
    evt_item_t it;
    int        idx;
    idx = (cls == CLASS_A) ? 1 : 0;
    if (send_idle && $urandom_range(0, 4) == 0) begin
      evt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    it.mode         = mode;
    it.class_a      = cls;
    it.timestamp_ns = ts;
    evt_if.valid <= 1'b1;
    evt_if.data  <= it;
    @(posedge clk);
    while (!evt_if.ready) @(posedge clk);
    if (mode == MODE_ENTER) begin
      if (drv_depth[idx] < busy_union_scoreboard::CAP) drv_depth[idx]++;
    end else if (drv_depth[idx] > 0) begin
      drv_depth[idx]--;
    end
  endtask

  // stop sending until every pending report has come back
  task automatic drain_reports();
    evt_if.valid <= 1'b0;
    @(negedge clk);
    while (sb.outstanding() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [TS_W-1:0] rand_ts();
    return {$urandom, $urandom};
  endfunction

  initial begin
    #5_000_000;
    $display("timeout with %0d reports pending", sb.outstanding());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic     mode, cls;
    int       d, r;
    logic [TS_W-1:0] ts;
    evt_if.valid <= 1'b0;
    evt_if.data  <= '0;
    drv_depth[0] = 0;
    drv_depth[1] = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero start stamps: busy and overlap intervals opened at time zero
    push_event(MODE_ENTER, CLASS_A, 64'd0);
    push_event(MODE_ENTER, CLASS_B, 64'd0);
    push_event(MODE_EXIT,  CLASS_B, 64'd5);
    push_event(MODE_EXIT,  CLASS_A, 64'd9);
    // exits with nothing in flight
    push_event(MODE_EXIT,  CLASS_A, 64'd12);
    push_event(MODE_EXIT,  CLASS_B, 64'd13);
    // nested A with B overlap
    push_event(MODE_ENTER, CLASS_A, 64'd20);
    push_event(MODE_ENTER, CLASS_A, 64'd25);
    push_event(MODE_ENTER, CLASS_B, 64'd30);
    push_event(MODE_ENTER, CLASS_B, 64'd35);
    push_event(MODE_EXIT,  CLASS_A, 64'd40);
    push_event(MODE_EXIT,  CLASS_A, 64'd50);
    push_event(MODE_EXIT,  CLASS_B, 64'd60);
    push_event(MODE_EXIT,  CLASS_B, 64'd70);
    // timestamps going backwards across the 64-bit wrap
    push_event(MODE_ENTER, CLASS_A, '1);
    push_event(MODE_ENTER, CLASS_B, 64'hFFFF_FFFF_FFFF_FFF0);
    push_event(MODE_EXIT,  CLASS_A, 64'd5);
    push_event(MODE_EXIT,  CLASS_B, 64'h5555_5555_5555_5555);
    push_event(MODE_ENTER, CLASS_A, 64'hAAAA_AAAA_AAAA_AAAA);
    push_event(MODE_EXIT,  CLASS_A, 64'h8000_0000_0000_0000);
    // zero-length interval
    push_event(MODE_ENTER, CLASS_B, 64'd100);
    push_event(MODE_EXIT,  CLASS_B, 64'd100);
    drain_reports();

    // drive both classes past the in-flight cap, then drain past empty
    t_now = 64'd10_000;
    for (int i = 0; i < SAT_ENTERS; i++) begin
      cls = 1'($urandom_range(0, 1));
      t_now += TS_W'($urandom_range(1, 20));
      push_event(MODE_ENTER, cls, t_now);
      t_now += TS_W'($urandom_range(1, 20));
      push_event(MODE_ENTER, ~cls, t_now);
    end
    for (int i = 0; i < SAT_ENTERS; i++) begin
      cls = 1'($urandom_range(0, 1));
      t_now += TS_W'($urandom_range(1, 20));
      push_event(MODE_EXIT, cls, t_now);
      t_now += TS_W'($urandom_range(1, 20));
      push_event(MODE_EXIT, ~cls, t_now);
    end
    drain_reports();

    // random walk over both classes, mostly monotonic time
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == 200) begin
        hold_cycles = 80;
        hold_req    = 1'b1;
        send_idle   = 1'b0;
      end
      if (i == 240) send_idle = 1'b1;
      if (i == 500) drain_reports();
      if (i == RAND_ITEMS - 150) begin
        send_idle = 1'b0;
        recv_idle = 1'b0;
      end
      cls = 1'($urandom_range(0, 1));
      d   = drv_depth[(cls == CLASS_A) ? 1 : 0];
      if (d == 0)
        mode = ($urandom_range(0, 9) < 8) ? MODE_ENTER : MODE_EXIT;
      else if (d < 6)
        mode = $urandom_range(0, 1) ? MODE_ENTER : MODE_EXIT;
      else
        mode = ($urandom_range(0, 2) == 0) ? MODE_ENTER : MODE_EXIT;
      r = $urandom_range(0, 99);
      if (r < 2) begin
        t_now = rand_ts();
        ts    = t_now;
      end else if (r < 5) begin
        ts = rand_ts();
      end else begin
        t_now += TS_W'($urandom_range(0, 40));
        ts    = t_now;
      end
      push_event(mode, cls, ts);
    end

    drain_reports();
    repeat (6) @(posedge clk);

    $display("Covered %0d events: %0d enters, %0d empty exits, %0d saturated enters",
             sb.n_events, sb.n_enters, sb.n_empty_exits, sb.n_saturated);
    $display("%0d reports checked, peak depth A %0d B %0d, %0d mismatches",
             sb.n_checked, sb.a_pk, sb.b_pk, sb.errors);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
